/* hw/rtl/dlps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dlps_pkg
// Shared types and fixed field widths for the delayed loop playback
// scheduler.
// ----------------------------------------------------------------------------
package dlps_pkg;

    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 16;
    localparam int EVT_W    = 2;
    localparam int ACTIVE_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 2'd0,
        CMD_ARM      = 2'd1,
        CMD_STOP_ONE = 2'd2,
        CMD_STOP_ALL = 2'd3
    } cmd_t;

    typedef enum logic [EVT_W-1:0] {
        EVT_DONE = 2'd0,
        EVT_PLAY = 2'd1,
        EVT_STOP = 2'd2
    } evt_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARM,
        ST_STOP_ONE,
        ST_STOP_ALL,
        ST_SCAN,
        ST_START,
        ST_LOOP,
        ST_REPLAY,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/delayed_loop_playback_scheduler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// delayed_loop_playback_scheduler
// Table of playback slots held in one synchronous memory, with valid and
// started flags in flip-flops, and a sequencer that walks the slots.
//
//   Channel   Handshake            Payload
//   input     in_valid/in_ready    command, slot, now_ms, loop_count,
//                                  loop_length_ms, start_delay_ms
//   output    out_valid/out_ready  event_res, event_slot, found,
//                                  active_count, any_active, last
//
// One command is in work at a time; in_ready is high only in the idle state.
// A tick skips each free slot and takes each valid slot through memory read,
// start check, stop check and, where due, replay, then gives the done marker.
// Arm and stop-one go through their own state and then the done state;
// stop-all walks every slot. Every command is taken in the idle state.
// Every beat is held in one output register; the sequencer waits while it is
// full and not taken. Reset clears the slot flags at once; no clearing pass.
// ----------------------------------------------------------------------------
module delayed_loop_playback_scheduler #(
    parameter int NUM_SLOTS = 16,
    parameter int TIME_BITS = 48
) (
    input  wire                              clk,
    input  wire                              rst_n,

    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [dlps_pkg::CMD_W-1:0]       command,
    input  wire  [dlps_pkg::SLOT_W-1:0]      slot,
    input  wire  [TIME_BITS-1:0]             now_ms,
    input  wire  [dlps_pkg::COUNT_W-1:0]     loop_count,
    input  wire  [TIME_BITS-1:0]             loop_length_ms,
    input  wire  [TIME_BITS-1:0]             start_delay_ms,

    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [dlps_pkg::EVT_W-1:0]       event_res,
    output logic [dlps_pkg::SLOT_W-1:0]      event_slot,
    output logic                             found,
    output logic [dlps_pkg::ACTIVE_W-1:0]    active_count,
    output logic                             any_active,
    output logic                             last
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int CW    = dlps_pkg::COUNT_W;

    // Record layout: began_at | plays_done | plays_wanted | start_at | loop_length
    localparam int LEN_LO    = 0;
    localparam int START_LO  = TIME_BITS;
    localparam int WANTED_LO = 2 * TIME_BITS;
    localparam int DONE_LO   = 2 * TIME_BITS + CW;
    localparam int BEGAN_LO  = 2 * TIME_BITS + 2 * CW;
    localparam int REC_W     = 3 * TIME_BITS + 2 * CW;

    logic [REC_W-1:0] mem [NUM_SLOTS];
    logic [REC_W-1:0] rd_data_reg;

    dlps_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [NUM_SLOTS-1:0] started_reg, started_next;
    logic [CNT_W-1:0] active_reg, active_next;
    logic found_reg, found_next;

    dlps_pkg::cmd_t cmd_reg;
    logic [dlps_pkg::SLOT_W-1:0] slot_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [CW-1:0] count_reg;
    logic [TIME_BITS-1:0] len_reg;
    logic [TIME_BITS-1:0] delay_reg;
    logic [TIME_BITS-1:0] began_reg, began_next;
    logic [CW-1:0] pdone_reg, pdone_next;

    logic out_valid_reg;
    dlps_pkg::evt_t evt_reg;
    logic [dlps_pkg::SLOT_W-1:0] evt_slot_reg;
    logic found_out_reg;
    logic [CNT_W-1:0] count_out_reg;
    logic any_reg;
    logic last_reg;

    logic in_fire;
    logic out_free;
    logic emit;
    dlps_pkg::evt_t emit_res;
    logic [dlps_pkg::SLOT_W-1:0] emit_slot;
    logic emit_done;
    logic rd_en;
    logic wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [REC_W-1:0] wr_data;
    logic adv;
    logic is_last;
    logic slot_ok;
    logic [IDX_W-1:0] sidx;
    logic [TIME_BITS:0] arm_sum;
    logic [TIME_BITS-1:0] arm_start;
    logic [TIME_BITS-1:0] elapsed;
    logic [CW-1:0] pdone_inc;

    logic [TIME_BITS-1:0] rd_len;
    logic [TIME_BITS-1:0] rd_start;
    logic [CW-1:0] rd_wanted;
    logic [CW-1:0] rd_done;
    logic [TIME_BITS-1:0] rd_began;

    assign rd_len    = rd_data_reg[LEN_LO +: TIME_BITS];
    assign rd_start  = rd_data_reg[START_LO +: TIME_BITS];
    assign rd_wanted = rd_data_reg[WANTED_LO +: CW];
    assign rd_done   = rd_data_reg[DONE_LO +: CW];
    assign rd_began  = rd_data_reg[BEGAN_LO +: TIME_BITS];

    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign is_last   = (idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign slot_ok   = (32'(slot_reg) < NUM_SLOTS);
    assign sidx      = IDX_W'(slot_reg);
    assign arm_sum   = {1'b0, now_reg} + {1'b0, delay_reg};
    assign arm_start = arm_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : arm_sum[TIME_BITS-1:0];
    assign elapsed   = now_reg - began_reg;
    assign pdone_inc = pdone_reg + CW'(1);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        valid_next   = valid_reg;
        started_next = started_reg;
        active_next  = active_reg;
        found_next   = found_reg;
        began_next   = began_reg;
        pdone_next   = pdone_reg;
        in_ready     = 1'b0;
        emit         = 1'b0;
        emit_res     = dlps_pkg::EVT_DONE;
        emit_slot    = '0;
        emit_done    = 1'b0;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = {began_reg, pdone_reg, rd_wanted, rd_start, rd_len};
        adv          = 1'b0;

        unique case (state_reg)
            dlps_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    unique case (dlps_pkg::cmd_t'(command))
                        dlps_pkg::CMD_TICK:     state_next = dlps_pkg::ST_SCAN;
                        dlps_pkg::CMD_ARM:      state_next = dlps_pkg::ST_ARM;
                        dlps_pkg::CMD_STOP_ONE: state_next = dlps_pkg::ST_STOP_ONE;
                        dlps_pkg::CMD_STOP_ALL: state_next = dlps_pkg::ST_STOP_ALL;
                    endcase
                end
            end

            dlps_pkg::ST_ARM:
            begin
                if (slot_ok)
                begin
                    wr_en   = 1'b1;
                    wr_addr = sidx;
                    wr_data = {{TIME_BITS{1'b0}}, {CW{1'b0}}, count_reg, arm_start, len_reg};
                    if (!valid_reg[sidx])
                    begin
                        active_next = active_reg + CNT_W'(1);
                    end
                    valid_next[sidx]   = 1'b1;
                    started_next[sidx] = 1'b0;
                end
                state_next = dlps_pkg::ST_DONE;
            end

            dlps_pkg::ST_STOP_ONE:
            begin
                if (slot_ok && valid_reg[sidx])
                begin
                    emit      = 1'b1;
                    emit_res  = dlps_pkg::EVT_STOP;
                    emit_slot = slot_reg;
                    if (out_free)
                    begin
                        valid_next[sidx]   = 1'b0;
                        started_next[sidx] = 1'b0;
                        active_next        = active_reg - CNT_W'(1);
                        found_next         = 1'b1;
                        state_next         = dlps_pkg::ST_DONE;
                    end
                end
                else
                begin
                    state_next = dlps_pkg::ST_DONE;
                end
            end

            dlps_pkg::ST_STOP_ALL:
            begin
                if (valid_reg[idx_reg])
                begin
                    emit      = 1'b1;
                    emit_res  = dlps_pkg::EVT_STOP;
                    emit_slot = dlps_pkg::SLOT_W'(idx_reg);
                    if (out_free)
                    begin
                        valid_next[idx_reg]   = 1'b0;
                        started_next[idx_reg] = 1'b0;
                        active_next           = active_reg - CNT_W'(1);
                        adv                   = 1'b1;
                    end
                end
                else
                begin
                    adv = 1'b1;
                end
            end

            dlps_pkg::ST_SCAN:
            begin
                if (valid_reg[idx_reg])
                begin
                    rd_en      = 1'b1;
                    state_next = dlps_pkg::ST_START;
                end
                else
                begin
                    adv = 1'b1;
                end
            end

            dlps_pkg::ST_START:
            begin
                pdone_next = rd_done;
                if (!started_reg[idx_reg] && (rd_start <= now_reg))
                begin
                    emit      = 1'b1;
                    emit_res  = dlps_pkg::EVT_PLAY;
                    emit_slot = dlps_pkg::SLOT_W'(idx_reg);
                    if (out_free)
                    begin
                        began_next            = now_reg;
                        started_next[idx_reg] = 1'b1;
                        state_next            = dlps_pkg::ST_LOOP;
                    end
                end
                else
                begin
                    began_next = rd_began;
                    state_next = dlps_pkg::ST_LOOP;
                end
            end

            dlps_pkg::ST_LOOP:
            begin
                if (started_reg[idx_reg] && (rd_len <= elapsed))
                begin
                    emit      = 1'b1;
                    emit_res  = dlps_pkg::EVT_STOP;
                    emit_slot = dlps_pkg::SLOT_W'(idx_reg);
                    if (out_free)
                    begin
                        if (rd_wanted != '0)
                        begin
                            pdone_next = pdone_inc;
                            if (pdone_inc == rd_wanted)
                            begin
                                valid_next[idx_reg]   = 1'b0;
                                started_next[idx_reg] = 1'b0;
                                active_next           = active_reg - CNT_W'(1);
                                adv                   = 1'b1;
                            end
                            else
                            begin
                                state_next = dlps_pkg::ST_REPLAY;
                            end
                        end
                        else
                        begin
                            state_next = dlps_pkg::ST_REPLAY;
                        end
                    end
                end
                else
                begin
                    wr_en = 1'b1;
                    adv   = 1'b1;
                end
            end

            dlps_pkg::ST_REPLAY:
            begin
                emit      = 1'b1;
                emit_res  = dlps_pkg::EVT_PLAY;
                emit_slot = dlps_pkg::SLOT_W'(idx_reg);
                if (out_free)
                begin
                    began_next = now_reg;
                    wr_en      = 1'b1;
                    wr_data    = {now_reg, pdone_reg, rd_wanted, rd_start, rd_len};
                    adv        = 1'b1;
                end
            end

            dlps_pkg::ST_DONE:
            begin
                emit      = 1'b1;
                emit_done = 1'b1;
                if (out_free)
                begin
                    state_next = dlps_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dlps_pkg::ST_IDLE;
            end
        endcase

        if (adv)
        begin
            if (is_last)
            begin
                state_next = dlps_pkg::ST_DONE;
            end
            else
            begin
                idx_next   = idx_reg + IDX_W'(1);
                state_next = (cmd_reg == dlps_pkg::CMD_TICK) ? dlps_pkg::ST_SCAN
                                                             : dlps_pkg::ST_STOP_ALL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dlps_pkg::ST_IDLE;
            idx_reg       <= '0;
            valid_reg     <= '0;
            started_reg   <= '0;
            active_reg    <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            valid_reg   <= valid_next;
            started_reg <= started_next;
            active_reg  <= active_next;
            found_reg   <= found_next;
            if (emit && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        began_reg <= began_next;
        pdone_reg <= pdone_next;
        if (in_fire)
        begin
            cmd_reg   <= dlps_pkg::cmd_t'(command);
            slot_reg  <= slot;
            now_reg   <= now_ms;
            count_reg <= loop_count;
            len_reg   <= loop_length_ms;
            delay_reg <= start_delay_ms;
        end
        if (emit && out_free)
        begin
            evt_reg       <= emit_res;
            evt_slot_reg  <= emit_slot;
            found_out_reg <= emit_done && found_reg;
            count_out_reg <= emit_done ? active_reg : '0;
            any_reg       <= emit_done && (active_reg != '0);
            last_reg      <= emit_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = evt_reg;
    assign event_slot   = evt_slot_reg;
    assign found        = found_out_reg;
    assign active_count = dlps_pkg::ACTIVE_W'(count_out_reg);
    assign any_active   = any_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

/* tb/tb_delayed_loop_playback_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delayed_loop_playback_scheduler
// Self-checking bench for the delayed loop playback scheduler. A slot-table
// predictor inside the bench works out the play, stop and done beats for
// every accepted command. A checker compares each output beat with the oldest
// prediction. The bench runs directed cases, a back-pressure case and
// randomised sequences under several idling mixes.
// ----------------------------------------------------------------------------
module tb_delayed_loop_playback_scheduler;

    localparam int NUM_SLOTS = 16;
    localparam int TIME_BITS = 48;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef struct packed {
        dlps_pkg::evt_t                res;
        logic [dlps_pkg::SLOT_W-1:0]   slot;
        logic                          found;
        logic [dlps_pkg::ACTIVE_W-1:0] active;
        logic                          any_on;
        logic                          last;
    } sched_event_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    dlps_pkg::cmd_t                  command = dlps_pkg::CMD_TICK;
    logic [dlps_pkg::SLOT_W-1:0]     slot = '0;
    logic [TIME_BITS-1:0]            now_ms = '0;
    logic [dlps_pkg::COUNT_W-1:0]    loop_count = '0;
    logic [TIME_BITS-1:0]            loop_length_ms = '0;
    logic [TIME_BITS-1:0]            start_delay_ms = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [dlps_pkg::EVT_W-1:0]      event_res;
    logic [dlps_pkg::SLOT_W-1:0]     event_slot;
    logic                            found;
    logic [dlps_pkg::ACTIVE_W-1:0]   active_count;
    logic                            any_active;
    logic                            last;

    logic                            slot_armed   [NUM_SLOTS];
    logic                            slot_playing [NUM_SLOTS];
    logic [TIME_BITS-1:0]            due_at       [NUM_SLOTS];
    logic [TIME_BITS-1:0]            loop_len     [NUM_SLOTS];
    logic [TIME_BITS-1:0]            started_at   [NUM_SLOTS];
    logic [dlps_pkg::COUNT_W-1:0]    plays_goal   [NUM_SLOTS];
    logic [dlps_pkg::COUNT_W-1:0]    plays_made   [NUM_SLOTS];

    sched_event_t                    pending_events[$];
    int                              mismatch_count = 0;
    int                              send_idle_pct = 0;
    int                              recv_idle_pct = 0;
    int                              recv_hold_cycles = 0;
    logic                            recv_hold = 1'b0;
    logic [TIME_BITS-1:0]            clock_ms = '0;

    delayed_loop_playback_scheduler #(
        .NUM_SLOTS(NUM_SLOTS),
        .TIME_BITS(TIME_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .slot(slot),
        .now_ms(now_ms),
        .loop_count(loop_count),
        .loop_length_ms(loop_length_ms),
        .start_delay_ms(start_delay_ms),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .event_res(event_res),
        .event_slot(event_slot),
        .found(found),
        .active_count(active_count),
        .any_active(any_active),
        .last(last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic void queue_event(sched_event_t e);
        pending_events.insert(pending_events.size(), e);
    endfunction

    function automatic void push_event(dlps_pkg::evt_t res, int unsigned idx);
        sched_event_t e;
        e = '0;
        e.res = res;
        e.slot = dlps_pkg::SLOT_W'(idx);
        queue_event(e);
    endfunction

    function automatic void free_slot(int unsigned idx);
        slot_armed[idx] = 1'b0;
        slot_playing[idx] = 1'b0;
    endfunction

    function automatic void predict_events(dlps_pkg::cmd_t cmd,
            logic [dlps_pkg::SLOT_W-1:0] s,
            logic [TIME_BITS-1:0] now, logic [dlps_pkg::COUNT_W-1:0] count,
            logic [TIME_BITS-1:0] len, logic [TIME_BITS-1:0] delay);
        logic [TIME_BITS:0]   sum;
        logic [TIME_BITS-1:0] elapsed;
        logic                 hit;
        int unsigned          occupied;
        sched_event_t         marker;
        hit = 1'b0;
        occupied = 0;
        unique case (cmd)
            dlps_pkg::CMD_TICK:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (slot_armed[i])
                    begin
                        if (!slot_playing[i] && due_at[i] <= now)
                        begin
                            push_event(dlps_pkg::EVT_PLAY, i);
                            started_at[i] = now;
                            slot_playing[i] = 1'b1;
                        end
                        elapsed = now - started_at[i];
                        if (slot_playing[i] && loop_len[i] <= elapsed)
                        begin
                            push_event(dlps_pkg::EVT_STOP, i);
                            if (plays_goal[i] != 0)
                                plays_made[i] = plays_made[i] + dlps_pkg::COUNT_W'(1);
                            if (plays_goal[i] != 0 && plays_made[i] == plays_goal[i])
                                free_slot(i);
                            else
                            begin
                                push_event(dlps_pkg::EVT_PLAY, i);
                                started_at[i] = now;
                            end
                        end
                    end
                end
            end
            dlps_pkg::CMD_ARM:
            begin
                if (int'(s) < NUM_SLOTS)
                begin
                    sum = {1'b0, now} + {1'b0, delay};
                    slot_armed[s] = 1'b1;
                    slot_playing[s] = 1'b0;
                    due_at[s] = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
                    loop_len[s] = len;
                    started_at[s] = '0;
                    plays_goal[s] = count;
                    plays_made[s] = '0;
                end
            end
            dlps_pkg::CMD_STOP_ONE:
            begin
                if (int'(s) < NUM_SLOTS && slot_armed[s])
                begin
                    push_event(dlps_pkg::EVT_STOP, s);
                    free_slot(s);
                    hit = 1'b1;
                end
            end
            default:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (slot_armed[i])
                    begin
                        push_event(dlps_pkg::EVT_STOP, i);
                        free_slot(i);
                    end
                end
            end
        endcase
        for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_armed[i])
                occupied++;
        marker = '0;
        marker.res = dlps_pkg::EVT_DONE;
        marker.found = hit;
        marker.active = dlps_pkg::ACTIVE_W'(occupied);
        marker.any_on = (occupied != 0);
        marker.last = 1'b1;
        queue_event(marker);
    endfunction

    function automatic string describe(sched_event_t e);
        return $sformatf("res=%0d slot=%0d found=%0b active=%0d any=%0b last=%0b",
                         e.res, e.slot, e.found, e.active, e.any_on, e.last);
    endfunction

    function automatic logic [TIME_BITS-1:0] rand_time();
        return TIME_BITS'({$urandom(), $urandom()});
    endfunction

    always @(negedge clk)
        out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

    always
    begin
        @(posedge clk);
        if (recv_hold_cycles != 0)
        begin
            recv_hold = 1'b1;
            repeat (recv_hold_cycles) @(posedge clk);
            recv_hold_cycles = 0;
            recv_hold = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        sched_event_t seen;
        sched_event_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen.res = dlps_pkg::evt_t'(event_res);
            seen.slot = event_slot;
            seen.found = found;
            seen.active = active_count;
            seen.any_on = any_active;
            seen.last = last;
            if (pending_events.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected beat: expected none, got %s", describe(seen));
            end
            else
            begin
                want = pending_events.pop_front();
                if (seen.res !== want.res || seen.slot !== want.slot
                    || seen.found !== want.found || seen.active !== want.active
                    || seen.any_on !== want.any_on || seen.last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("beat mismatch: expected %s, got %s",
                                 describe(want), describe(seen));
                end
            end
        end
    end

    task automatic send_command(input dlps_pkg::cmd_t cmd,
            input logic [dlps_pkg::SLOT_W-1:0] s,
            input logic [TIME_BITS-1:0] now, input logic [dlps_pkg::COUNT_W-1:0] count,
            input logic [TIME_BITS-1:0] len, input logic [TIME_BITS-1:0] delay);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        slot <= s;
        now_ms <= now;
        loop_count <= count;
        loop_length_ms <= len;
        start_delay_ms <= delay;
        do
            @(posedge clk);
        while (!in_ready);
        predict_events(cmd, s, now, count, len, delay);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic test_directed();
        send_command(dlps_pkg::CMD_TICK,     4'd0,  '0,           '0,       '0,       '0);
        send_command(dlps_pkg::CMD_ARM,      4'd0,  '0,           16'd2,    48'd3,    '0);
        send_command(dlps_pkg::CMD_ARM,      4'd15, '0,           '0,       '0,       48'd2);
        send_command(dlps_pkg::CMD_TICK,     4'd0,  48'd0,        '0,       '0,       '0);
        send_command(dlps_pkg::CMD_TICK,     4'd0,  48'd2,        '0,       '0,       '0);
        send_command(dlps_pkg::CMD_TICK,     4'd0,  48'd3,        '0,       '0,       '0);
        send_command(dlps_pkg::CMD_TICK,     4'd0,  48'd6,        '0,       '0,       '0);
        send_command(dlps_pkg::CMD_ARM,      4'd5,  48'd6,        16'hFFFF, TIME_MAX, TIME_MAX);
        send_command(dlps_pkg::CMD_ARM,      4'd5,  48'd6,        16'd1,    48'd1,    48'd1);
        send_command(dlps_pkg::CMD_STOP_ONE, 4'd3,  48'd6,        '0,       '0,       '0);
        send_command(dlps_pkg::CMD_STOP_ONE, 4'd15, 48'd6,        '0,       '0,       '0);
        send_command(dlps_pkg::CMD_TICK,     4'd0,  48'd7,        '0,       '0,       '0);
        send_command(dlps_pkg::CMD_TICK,     4'd0,  48'd2,        '0,       '0,       '0);
        send_command(dlps_pkg::CMD_ARM,      4'd7,  TIME_MAX,     16'd3,    '0,       48'd5);
        send_command(dlps_pkg::CMD_ARM,      4'd8,  TIME_MAX - 1, '0,       TIME_MAX, '0);
        send_command(dlps_pkg::CMD_TICK,     4'd0,  TIME_MAX - 1, '0,       '0,       '0);
        send_command(dlps_pkg::CMD_TICK,     4'd0,  TIME_MAX,     '0,       '0,       '0);
        send_command(dlps_pkg::CMD_STOP_ALL, 4'd0,  TIME_MAX,     '0,       '0,       '0);
        send_command(dlps_pkg::CMD_STOP_ALL, 4'd0,  TIME_MAX,     '0,       '0,       '0);
        wait_for_results();
        clock_ms = '0;
    endtask

    task automatic test_backpressure();
        @(negedge clk);
        recv_hold_cycles = 400;
        clock_ms = 48'd1000;
        for (int i = 0; i < NUM_SLOTS; i++)
            send_command(dlps_pkg::CMD_ARM, dlps_pkg::SLOT_W'(i), clock_ms, '0, '0, '0);
        send_command(dlps_pkg::CMD_TICK, 4'd0, clock_ms, '0, '0, '0);
        send_command(dlps_pkg::CMD_TICK, 4'd0, clock_ms + 1, '0, '0, '0);
        send_command(dlps_pkg::CMD_STOP_ALL, 4'd0, clock_ms + 1, '0, '0, '0);
        wait_for_results();
    endtask

    task automatic test_random(input int items);
        int unsigned    roll;
        dlps_pkg::cmd_t cmd;
        for (int n = 0; n < items; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 45)
            begin
                clock_ms = clock_ms + $urandom_range(0, 6);
                send_command(dlps_pkg::CMD_TICK, dlps_pkg::SLOT_W'($urandom), clock_ms,
                             '0, '0, '0);
            end
            else if (roll < 75)
                send_command(dlps_pkg::CMD_ARM, dlps_pkg::SLOT_W'($urandom), clock_ms,
                             dlps_pkg::COUNT_W'($urandom_range(0, 4)),
                             TIME_BITS'($urandom_range(0, 10)),
                             TIME_BITS'($urandom_range(0, 12)));
            else if (roll < 83)
                send_command(dlps_pkg::CMD_STOP_ONE, dlps_pkg::SLOT_W'($urandom), clock_ms,
                             '0, '0, '0);
            else if (roll < 86)
                send_command(dlps_pkg::CMD_STOP_ALL, dlps_pkg::SLOT_W'($urandom), clock_ms,
                             '0, '0, '0);
            else if (roll < 90)
            begin
                wait_for_results();
                clock_ms = clock_ms + 1;
                send_command(dlps_pkg::CMD_TICK, '0, clock_ms, '0, '0, '0);
            end
            else
            begin
                cmd = dlps_pkg::cmd_t'($urandom_range(0, 3));
                if (cmd == dlps_pkg::CMD_TICK)
                    clock_ms = rand_time();
                send_command(cmd, dlps_pkg::SLOT_W'($urandom),
                             cmd == dlps_pkg::CMD_TICK ? clock_ms : rand_time(),
                             dlps_pkg::COUNT_W'($urandom), rand_time(), rand_time());
            end
        end
        wait_for_results();
    endtask

    initial
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_armed[i] = 1'b0;
            slot_playing[i] = 1'b0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 15;
        recv_idle_pct = 61;
        test_directed();
        test_random(40);

        send_idle_pct = 61;
        recv_idle_pct = 15;
        test_random(40);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(40);

        wait_for_results();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/dlps_pkg.sv
hw/rtl/delayed_loop_playback_scheduler.sv
tb/tb_delayed_loop_playback_scheduler.sv
